[hw/rtl/cmdsplit_pkg.sv]
package cmdsplit_pkg;

   // Parser modes.
   localparam logic [2:0] MODE_BETWEEN = 3'd0;
   localparam logic [2:0] MODE_BARE    = 3'd1;
   localparam logic [2:0] MODE_SINGLE  = 3'd2;
   localparam logic [2:0] MODE_DOUBLE  = 3'd3;
   localparam logic [2:0] MODE_IGNORE  = 3'd4;

   // Result kinds.
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_END_ARG = 2'd1;
   localparam logic [1:0] KIND_END_CMD = 2'd2;

   // Characters with a special meaning.
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   localparam int MAX_ARGS_DEFAULT = 256;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [7:0] arg_total;
      logic       last_of_run;
   } result_type;

   // Up to three results caused by one input byte.
   typedef struct packed {
      logic [1:0]           count;
      result_type [2:0]     item;
   } bundle_type;

endpackage

[hw/rtl/command_line_argument_splitter.sv]
// Channel   Ports                                        Direction  Moves
// req       req_valid, req_ready, req_in_byte            in         one command byte
// rsp       rsp_valid, rsp_ready, rsp_kind, rsp_out_byte, out        one result
//           rsp_arg_total, rsp_last_of_run
//
// A byte is decoded in the cycle it is accepted; its first result is offered in the cycle after.
// Results leave one per cycle while rsp_ready is high, and a byte with several results holds
// off the next byte until its last result leaves.
// Reset is synchronous: the parser returns to between arguments with a zero count and the
// result register empties. A stalled rsp holds its transaction and blocks new bytes unless
// the last pending result leaves in the same cycle.
module command_line_argument_splitter #(
   parameter int MaxArgs = cmdsplit_pkg::MAX_ARGS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [7:0] rsp_arg_total,
   output logic       rsp_last_of_run
);

   // A transaction on req is accepted when the result register can take the new bundle.
   logic                     accept;
   cmdsplit_pkg::bundle_type bundle;
   cmdsplit_pkg::result_type item;

   assign accept = req_valid && req_ready;

   // The parser holds the mode, the pending backslash and the argument count, and turns
   // one byte into the list of results it causes.
   cmdsplit_parser #(
      .MaxArgs (MaxArgs)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .bundle  (bundle)
   );

   // The result register presents the results one transaction at a time.
   cmdsplit_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .bundle     (bundle),
      .load_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_item   (item)
   );

   assign rsp_kind        = item.kind;
   assign rsp_out_byte    = item.out_byte;
   assign rsp_arg_total   = item.arg_total;
   assign rsp_last_of_run = item.last_of_run;

endmodule

[hw/rtl/cmdsplit_parser.sv]
module cmdsplit_parser #(
   parameter int MaxArgs = cmdsplit_pkg::MAX_ARGS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               in_byte,
   output cmdsplit_pkg::bundle_type bundle
);

   localparam int          CapInt = (MaxArgs - 1 > 255) ? 255 : MaxArgs - 1;
   localparam logic [7:0]  ArgCap = 8'(CapInt);

   logic [2:0] mode_ff, mode_in;
   logic       bs_ff, bs_in;
   logic [7:0] cnt_ff, cnt_in;

   function automatic cmdsplit_pkg::bundle_type push(
      input cmdsplit_pkg::bundle_type b,
      input logic [1:0] kind,
      input logic [7:0] val,
      input logic [7:0] total
   );
      cmdsplit_pkg::bundle_type r;
      r = b;
      r.item[b.count].kind        = kind;
      r.item[b.count].out_byte    = val;
      r.item[b.count].arg_total   = total;
      r.item[b.count].last_of_run = 1'b0;
      r.count = b.count + 2'd1;
      return r;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c >= 8'd9 && c <= 8'd13) || c == cmdsplit_pkg::CHAR_SPACE;
   endfunction

   always_comb begin
      cmdsplit_pkg::bundle_type b;
      logic in_arg;
      b       = '0;
      mode_in = mode_ff;
      bs_in   = bs_ff;
      cnt_in  = cnt_ff;
      in_arg  = (mode_ff == cmdsplit_pkg::MODE_BARE) || (mode_ff == cmdsplit_pkg::MODE_SINGLE)
                || (mode_ff == cmdsplit_pkg::MODE_DOUBLE);
      if (in_byte == cmdsplit_pkg::CHAR_NUL) begin
         if (in_arg && bs_ff) begin
            b = push(b, cmdsplit_pkg::KIND_BYTE, cmdsplit_pkg::CHAR_BACKSLASH, 8'd0);
         end
         if (in_arg) begin
            b = push(b, cmdsplit_pkg::KIND_END_ARG, 8'd0, 8'd0);
         end
         b       = push(b, cmdsplit_pkg::KIND_END_CMD, 8'd0, cnt_ff);
         mode_in = cmdsplit_pkg::MODE_BETWEEN;
         bs_in   = 1'b0;
         cnt_in  = 8'd0;
      end else begin
         unique case (mode_ff)
            cmdsplit_pkg::MODE_IGNORE: begin
            end
            cmdsplit_pkg::MODE_SINGLE: begin
               if (in_byte == cmdsplit_pkg::CHAR_SQUOTE) begin
                  b       = push(b, cmdsplit_pkg::KIND_END_ARG, 8'd0, 8'd0);
                  mode_in = cmdsplit_pkg::MODE_BETWEEN;
               end else begin
                  b = push(b, cmdsplit_pkg::KIND_BYTE, in_byte, 8'd0);
               end
            end
            cmdsplit_pkg::MODE_DOUBLE: begin
               if (bs_ff) begin
                  bs_in = 1'b0;
                  if (!(in_byte == cmdsplit_pkg::CHAR_DQUOTE
                        || in_byte == cmdsplit_pkg::CHAR_BACKSLASH
                        || in_byte == cmdsplit_pkg::CHAR_NEWLINE)) begin
                     b = push(b, cmdsplit_pkg::KIND_BYTE, cmdsplit_pkg::CHAR_BACKSLASH, 8'd0);
                  end
                  b = push(b, cmdsplit_pkg::KIND_BYTE, in_byte, 8'd0);
               end else if (in_byte == cmdsplit_pkg::CHAR_DQUOTE) begin
                  b       = push(b, cmdsplit_pkg::KIND_END_ARG, 8'd0, 8'd0);
                  mode_in = cmdsplit_pkg::MODE_BETWEEN;
               end else if (in_byte == cmdsplit_pkg::CHAR_BACKSLASH) begin
                  bs_in = 1'b1;
               end else begin
                  b = push(b, cmdsplit_pkg::KIND_BYTE, in_byte, 8'd0);
               end
            end
            cmdsplit_pkg::MODE_BARE: begin
               if (bs_ff) begin
                  bs_in = 1'b0;
                  b     = push(b, cmdsplit_pkg::KIND_BYTE, in_byte, 8'd0);
               end else if (is_ws(in_byte)) begin
                  b       = push(b, cmdsplit_pkg::KIND_END_ARG, 8'd0, 8'd0);
                  mode_in = cmdsplit_pkg::MODE_BETWEEN;
               end else if (in_byte == cmdsplit_pkg::CHAR_BACKSLASH) begin
                  bs_in = 1'b1;
               end else begin
                  b = push(b, cmdsplit_pkg::KIND_BYTE, in_byte, 8'd0);
               end
            end
            default: begin
               // Between arguments; unused codes behave the same way.
               if (!is_ws(in_byte)) begin
                  if (cnt_ff >= ArgCap) begin
                     mode_in = cmdsplit_pkg::MODE_IGNORE;
                  end else begin
                     cnt_in = cnt_ff + 8'd1;
                     bs_in  = 1'b0;
                     if (in_byte == cmdsplit_pkg::CHAR_SQUOTE) begin
                        mode_in = cmdsplit_pkg::MODE_SINGLE;
                     end else if (in_byte == cmdsplit_pkg::CHAR_DQUOTE) begin
                        mode_in = cmdsplit_pkg::MODE_DOUBLE;
                     end else begin
                        mode_in = cmdsplit_pkg::MODE_BARE;
                        if (in_byte == cmdsplit_pkg::CHAR_BACKSLASH) begin
                           bs_in = 1'b1;
                        end else begin
                           b = push(b, cmdsplit_pkg::KIND_BYTE, in_byte, 8'd0);
                        end
                     end
                  end
               end
            end
         endcase
      end
      for (int i = 0; i < 3; i++) begin
         b.item[i].last_of_run = (b.count != 2'd0) && (2'(i) == b.count - 2'd1);
      end
      bundle = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= cmdsplit_pkg::MODE_BETWEEN;
         bs_ff   <= 1'b0;
         cnt_ff  <= 8'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         bs_ff   <= bs_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

[hw/rtl/cmdsplit_outq.sv]
module cmdsplit_outq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  cmdsplit_pkg::bundle_type bundle,
   output logic                     load_ready,
   output logic                     out_valid,
   input  logic                     out_ready,
   output cmdsplit_pkg::result_type out_item
);

   logic [1:0]                    rem_ff, rem_in;
   cmdsplit_pkg::result_type [2:0] item_ff, item_in;
   logic                          pop;

   assign pop        = (rem_ff != 2'd0) && out_ready;
   assign load_ready = (rem_ff == 2'd0) || ((rem_ff == 2'd1) && out_ready);
   assign out_valid  = (rem_ff != 2'd0);
   assign out_item   = item_ff[0];

   always_comb begin
      rem_in  = rem_ff;
      item_in = item_ff;
      if (load) begin
         rem_in  = bundle.count;
         item_in = bundle.item;
      end else if (pop) begin
         rem_in     = rem_ff - 2'd1;
         item_in[0] = item_ff[1];
         item_in[1] = item_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

[hw/rtl/cmdsplit_checker.sv]
module cmdsplit_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic [7:0] rsp_arg_total,
   input logic       rsp_last_of_run
);

   // A stalled result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte)
                                  && $stable(rsp_arg_total) && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind == cmdsplit_pkg::KIND_BYTE || rsp_kind == cmdsplit_pkg::KIND_END_ARG
                    || rsp_kind == cmdsplit_pkg::KIND_END_CMD)
      else $error("illegal result kind");

   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == cmdsplit_pkg::KIND_BYTE || rsp_out_byte == 8'd0)
                    && (rsp_kind == cmdsplit_pkg::KIND_END_CMD || rsp_arg_total == 8'd0))
      else $error("unused result field not zero");

   a_end_cmd_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == cmdsplit_pkg::KIND_END_CMD |-> rsp_last_of_run)
      else $error("end of command is not the last result of its byte");

   // A byte is only taken when no earlier result other than the leaving one is pending.
   a_accept_drained: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_valid |-> rsp_ready && rsp_last_of_run)
      else $error("byte accepted while earlier results pending");

endmodule

bind command_line_argument_splitter cmdsplit_checker u_cmdsplit_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_kind        (rsp_kind),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_arg_total   (rsp_arg_total),
   .rsp_last_of_run (rsp_last_of_run)
);

[verif/command_line_argument_splitter_checker.sv]
`timescale 1ns / 100ps

module command_line_argument_splitter_checker #(
   parameter int MaxArgs = cmdsplit_pkg::MAX_ARGS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [1:0] rsp_kind,
   input  logic [7:0] rsp_out_byte,
   input  logic [7:0] rsp_arg_total,
   input  logic       rsp_last_of_run,
   output int         mismatch_count,
   output int         stream_depth
);

   localparam int ARG_CAP = (MaxArgs - 1 > 255) ? 255 : MaxArgs - 1;

   // Parser state as seen from outside.
   logic [2:0] parse_mode;
   logic       escape_armed;
   logic [7:0] args_seen;

   cmdsplit_pkg::result_type step_pieces[$];
   cmdsplit_pkg::result_type argument_stream[$];

   function automatic bit is_blank(input logic [7:0] c);
      return (c >= 8'd9 && c <= 8'd13) || c == cmdsplit_pkg::CHAR_SPACE;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("%0t ns: %s", $time, msg);
      end
   endtask

   task automatic add_piece(input logic [1:0] k, input logic [7:0] b, input logic [7:0] t);
      cmdsplit_pkg::result_type r;
      r.kind        = k;
      r.out_byte    = b;
      r.arg_total   = t;
      r.last_of_run = 1'b0;
      step_pieces.push_back(r);
   endtask

   task automatic split_byte(input logic [7:0] c);
      logic [2:0] m;
      logic       in_word;
      cmdsplit_pkg::result_type r;
      m = (parse_mode > cmdsplit_pkg::MODE_IGNORE) ? cmdsplit_pkg::MODE_BETWEEN : parse_mode;
      in_word = (m == cmdsplit_pkg::MODE_BARE) || (m == cmdsplit_pkg::MODE_SINGLE)
                || (m == cmdsplit_pkg::MODE_DOUBLE);
      step_pieces.delete();
      if (c == cmdsplit_pkg::CHAR_NUL) begin
         if (in_word && escape_armed) begin
            add_piece(cmdsplit_pkg::KIND_BYTE, cmdsplit_pkg::CHAR_BACKSLASH, 8'd0);
         end
         if (in_word) begin
            add_piece(cmdsplit_pkg::KIND_END_ARG, 8'd0, 8'd0);
         end
         add_piece(cmdsplit_pkg::KIND_END_CMD, 8'd0, args_seen);
         parse_mode   = cmdsplit_pkg::MODE_BETWEEN;
         escape_armed = 1'b0;
         args_seen    = 8'd0;
      end else begin
         case (m)
            cmdsplit_pkg::MODE_IGNORE: ; // everything up to the zero byte is dropped
            cmdsplit_pkg::MODE_SINGLE: begin
               if (c == cmdsplit_pkg::CHAR_SQUOTE) begin
                  add_piece(cmdsplit_pkg::KIND_END_ARG, 8'd0, 8'd0);
                  parse_mode = cmdsplit_pkg::MODE_BETWEEN;
               end else begin
                  add_piece(cmdsplit_pkg::KIND_BYTE, c, 8'd0);
               end
            end
            cmdsplit_pkg::MODE_DOUBLE: begin
               if (escape_armed) begin
                  escape_armed = 1'b0;
                  if (!(c == cmdsplit_pkg::CHAR_DQUOTE || c == cmdsplit_pkg::CHAR_BACKSLASH
                        || c == cmdsplit_pkg::CHAR_NEWLINE)) begin
                     add_piece(cmdsplit_pkg::KIND_BYTE, cmdsplit_pkg::CHAR_BACKSLASH, 8'd0);
                  end
                  add_piece(cmdsplit_pkg::KIND_BYTE, c, 8'd0);
               end else if (c == cmdsplit_pkg::CHAR_DQUOTE) begin
                  add_piece(cmdsplit_pkg::KIND_END_ARG, 8'd0, 8'd0);
                  parse_mode = cmdsplit_pkg::MODE_BETWEEN;
               end else if (c == cmdsplit_pkg::CHAR_BACKSLASH) begin
                  escape_armed = 1'b1;
               end else begin
                  add_piece(cmdsplit_pkg::KIND_BYTE, c, 8'd0);
               end
            end
            cmdsplit_pkg::MODE_BARE: begin
               if (escape_armed) begin
                  escape_armed = 1'b0;
                  add_piece(cmdsplit_pkg::KIND_BYTE, c, 8'd0);
               end else if (is_blank(c)) begin
                  add_piece(cmdsplit_pkg::KIND_END_ARG, 8'd0, 8'd0);
                  parse_mode = cmdsplit_pkg::MODE_BETWEEN;
               end else if (c == cmdsplit_pkg::CHAR_BACKSLASH) begin
                  escape_armed = 1'b1;
               end else begin
                  add_piece(cmdsplit_pkg::KIND_BYTE, c, 8'd0);
               end
            end
            default: begin
               // Between arguments; unused mode codes land here as well.
               if (!is_blank(c)) begin
                  if (args_seen >= ARG_CAP) begin
                     parse_mode = cmdsplit_pkg::MODE_IGNORE;
                  end else begin
                     args_seen    = args_seen + 8'd1;
                     escape_armed = 1'b0;
                     if (c == cmdsplit_pkg::CHAR_SQUOTE) begin
                        parse_mode = cmdsplit_pkg::MODE_SINGLE;
                     end else if (c == cmdsplit_pkg::CHAR_DQUOTE) begin
                        parse_mode = cmdsplit_pkg::MODE_DOUBLE;
                     end else begin
                        parse_mode = cmdsplit_pkg::MODE_BARE;
                        if (c == cmdsplit_pkg::CHAR_BACKSLASH) begin
                           escape_armed = 1'b1;
                        end else begin
                           add_piece(cmdsplit_pkg::KIND_BYTE, c, 8'd0);
                        end
                     end
                  end
               end
            end
         endcase
      end
      foreach (step_pieces[i]) begin
         r = step_pieces[i];
         r.last_of_run = (i == step_pieces.size() - 1);
         argument_stream.push_back(r);
      end
   endtask

   task automatic check_piece();
      cmdsplit_pkg::result_type want;
      if (argument_stream.size() == 0) begin
         report_mismatch($sformatf("unexpected result: kind %0d byte %02h total %0d last %0b",
                                   rsp_kind, rsp_out_byte, rsp_arg_total, rsp_last_of_run));
      end else begin
         want = argument_stream.pop_front();
         if (rsp_kind !== want.kind || rsp_out_byte !== want.out_byte ||
             rsp_arg_total !== want.arg_total || rsp_last_of_run !== want.last_of_run) begin
            report_mismatch($sformatf(
               "result mismatch: kind %0d/%0d byte %02h/%02h total %0d/%0d last %0b/%0b (got/want)",
               rsp_kind, want.kind, rsp_out_byte, want.out_byte,
               rsp_arg_total, want.arg_total, rsp_last_of_run, want.last_of_run));
         end
      end
   endtask

   // The byte is predicted before the result is taken, so the order of the
   // stream holds even if a result could leave in the cycle its byte arrives.
   always @(posedge clock) begin
      if (reset) begin
         parse_mode   = cmdsplit_pkg::MODE_BETWEEN;
         escape_armed = 1'b0;
         args_seen    = 8'd0;
         argument_stream.delete();
      end else begin
         if (req_valid && req_ready) begin
            split_byte(req_in_byte);
         end
         if (rsp_valid && rsp_ready) begin
            check_piece();
         end
      end
      stream_depth = argument_stream.size();
   end

endmodule

[verif/command_line_argument_splitter_tb.sv]
`timescale 1ns / 100ps

module command_line_argument_splitter_tb;

   localparam int MAX_ARGS     = cmdsplit_pkg::MAX_ARGS_DEFAULT;
   // The count saturates at the smaller of MAX_ARGS-1 and the 8-bit limit.
   localparam int ARG_CAP      = (MAX_ARGS - 1 > 255) ? 255 : MAX_ARGS - 1;
   // Random bytes sent in ordinary commands; the argument flood comes on top.
   localparam int RANDOM_BYTES = 400;
   // The final stretch of the random part runs with both sides always ready.
   localparam int CALM_BYTES   = 60;
   // Results leave one per cycle while rsp_ready is high; these cycles after the drain catch a stray extra result.
   localparam int TAIL_CYCLES  = 16;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic [7:0] rsp_arg_total;
   logic       rsp_last_of_run;

   int         mismatch_count;
   int         stream_depth;

   // Set while random idling is allowed on both channels.
   logic       gaps_on;
   // The command that is about to be sent, zero byte included.
   logic [7:0] cmd_bytes[$];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   command_line_argument_splitter #(
      .MaxArgs(MAX_ARGS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_arg_total  (rsp_arg_total),
      .rsp_last_of_run(rsp_last_of_run)
   );

   command_line_argument_splitter_checker #(
      .MaxArgs(MAX_ARGS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_arg_total  (rsp_arg_total),
      .rsp_last_of_run(rsp_last_of_run),
      .mismatch_count (mismatch_count),
      .stream_depth   (stream_depth)
   );

   // One of the six separator bytes: tab through carriage return, or space.
   function automatic logic [7:0] random_blank();
      int k;
      k = $urandom_range(0, 5);
      return (k == 5) ? cmdsplit_pkg::CHAR_SPACE : 8'(9 + k);
   endfunction

   // Any nonzero byte other than the two given ones.
   function automatic logic [7:0] random_nonzero_except(input logic [7:0] a,
                                                        input logic [7:0] b);
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (c == a || c == b);
      return c;
   endfunction

   // A byte that is ordinary text in a bare word: never blank, never a
   // backslash, and a quote only when the caller allows one. Bytes with the
   // top bit set show up now and then.
   function automatic logic [7:0] random_word_char(input bit allow_quote);
      logic [7:0] c;
      if ($urandom_range(0, 5) == 0) begin
         return 8'($urandom_range(128, 255));
      end
      do c = 8'($urandom_range(33, 126));
      while (c == cmdsplit_pkg::CHAR_BACKSLASH ||
             (!allow_quote && (c == cmdsplit_pkg::CHAR_SQUOTE
                               || c == cmdsplit_pkg::CHAR_DQUOTE)));
      return c;
   endfunction

   task automatic add_blanks(input int lo, input int hi);
      repeat ($urandom_range(lo, hi)) cmd_bytes.push_back(random_blank());
   endtask

   // One argument: mostly well-formed bare, single-quoted or double-quoted
   // words with random content and escapes, sometimes plain noise.
   task automatic add_word();
      int len;
      int k;
      len = $urandom_range(0, 6);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            // Bare word. An opening backslash escapes whatever comes next.
            if ($urandom_range(0, 7) == 0) begin
               cmd_bytes.push_back(cmdsplit_pkg::CHAR_BACKSLASH);
               cmd_bytes.push_back(random_nonzero_except(cmdsplit_pkg::CHAR_NUL,
                                                         cmdsplit_pkg::CHAR_NUL));
            end else begin
               cmd_bytes.push_back(random_word_char(1'b0));
            end
            repeat (len) begin
               if ($urandom_range(0, 6) == 0) begin
                  cmd_bytes.push_back(cmdsplit_pkg::CHAR_BACKSLASH);
                  cmd_bytes.push_back(random_nonzero_except(cmdsplit_pkg::CHAR_NUL,
                                                            cmdsplit_pkg::CHAR_NUL));
               end else begin
                  // Quotes inside a bare word are plain text.
                  cmd_bytes.push_back(random_word_char(1'b1));
               end
            end
         end
         4, 5: begin
            // Single quotes: everything up to the closing quote is literal.
            cmd_bytes.push_back(cmdsplit_pkg::CHAR_SQUOTE);
            repeat (len) cmd_bytes.push_back(random_nonzero_except(cmdsplit_pkg::CHAR_SQUOTE,
                                                                   cmdsplit_pkg::CHAR_NUL));
            cmd_bytes.push_back(cmdsplit_pkg::CHAR_SQUOTE);
         end
         6, 7: begin
            // Double quotes, with both the three special escapes and escapes
            // of ordinary bytes, which keep their backslash.
            cmd_bytes.push_back(cmdsplit_pkg::CHAR_DQUOTE);
            repeat (len) begin
               case ($urandom_range(0, 7))
                  0: begin
                     k = $urandom_range(0, 2);
                     cmd_bytes.push_back(cmdsplit_pkg::CHAR_BACKSLASH);
                     cmd_bytes.push_back((k == 0) ? cmdsplit_pkg::CHAR_DQUOTE :
                                         (k == 1) ? cmdsplit_pkg::CHAR_BACKSLASH :
                                                    cmdsplit_pkg::CHAR_NEWLINE);
                  end
                  1: begin
                     cmd_bytes.push_back(cmdsplit_pkg::CHAR_BACKSLASH);
                     cmd_bytes.push_back(random_nonzero_except(cmdsplit_pkg::CHAR_NUL,
                                                               cmdsplit_pkg::CHAR_NUL));
                  end
                  default: begin
                     cmd_bytes.push_back(random_nonzero_except(cmdsplit_pkg::CHAR_DQUOTE,
                                                               cmdsplit_pkg::CHAR_BACKSLASH));
                  end
               endcase
            end
            cmd_bytes.push_back(cmdsplit_pkg::CHAR_DQUOTE);
         end
         default: begin
            // Noise: any nonzero bytes, unbalanced quotes included.
            repeat (len + 1) cmd_bytes.push_back(random_nonzero_except(cmdsplit_pkg::CHAR_NUL,
                                                                       cmdsplit_pkg::CHAR_NUL));
         end
      endcase
   endtask

   // A random command of up to six words. Some commands end in a broken
   // way: an unterminated quote, or a backslash right before the zero byte.
   task automatic add_command();
      int nargs;
      cmd_bytes.delete();
      if ($urandom_range(0, 3) == 0) begin
         add_blanks(1, 3);
      end
      nargs = $urandom_range(0, 6);
      for (int i = 0; i < nargs; i++) begin
         if (i > 0) begin
            add_blanks(1, 3);
         end
         add_word();
      end
      case ($urandom_range(0, 11))
         0: begin
            add_blanks(1, 2);
            cmd_bytes.push_back(cmdsplit_pkg::CHAR_SQUOTE);
            cmd_bytes.push_back(random_nonzero_except(cmdsplit_pkg::CHAR_SQUOTE,
                                                      cmdsplit_pkg::CHAR_NUL));
         end
         1: begin
            add_blanks(1, 2);
            cmd_bytes.push_back(cmdsplit_pkg::CHAR_DQUOTE);
            cmd_bytes.push_back(random_nonzero_except(cmdsplit_pkg::CHAR_DQUOTE,
                                                      cmdsplit_pkg::CHAR_BACKSLASH));
            cmd_bytes.push_back(cmdsplit_pkg::CHAR_BACKSLASH);
         end
         2: begin
            add_blanks(1, 2);
            cmd_bytes.push_back(random_word_char(1'b0));
            cmd_bytes.push_back(cmdsplit_pkg::CHAR_BACKSLASH);
         end
         3: add_blanks(1, 3);
         default: ;
      endcase
      cmd_bytes.push_back(cmdsplit_pkg::CHAR_NUL);
   endtask

   // A command with a few more arguments than the cap allows, so that the
   // parser saturates the count and drops the rest of the line.
   task automatic add_argument_flood();
      cmd_bytes.delete();
      for (int i = 0; i < ARG_CAP + 6; i++) begin
         if (i > 0) begin
            add_blanks(1, 1);
         end
         if ($urandom_range(0, 9) == 0) begin
            add_word();
         end else begin
            cmd_bytes.push_back(random_word_char(1'b0));
         end
      end
      cmd_bytes.push_back(cmdsplit_pkg::CHAR_NUL);
   endtask

   // Drives one byte at a falling edge and holds it until the rising edge at
   // which the block takes it. A random idle burst may come first.
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 9) == 0) begin
         req_valid   <= 1'b0;
         req_in_byte <= 8'($urandom());
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_command();
      foreach (cmd_bytes[i]) send_byte(cmd_bytes[i]);
   endtask

   // Result side: ready drops for random bursts while idling is allowed.
   // Decisions are made at falling edges, away from the sampling edge.
   initial begin
      int stall_left;
      rsp_ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int commands;
      int flood_at;
      int random_bytes;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_in_byte    = 8'd0;
      gaps_on        = 1'b0;
      repeat (7) @(posedge clock);
      gaps_on = 1'b1;
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening: an empty command, then a command that walks through
      // the separator extremes, the byte extremes, a quote inside a bare word,
      // literal single quotes, escapes of a quote, an ordinary byte and a newline
      // inside double quotes, empty quotes right after a closing quote, an escaped
      // blank in a bare word and a backslash right before the zero byte. An
      // unterminated double quote closes the opening.
      cmd_bytes = '{cmdsplit_pkg::CHAR_NUL,
                    8'h09, 8'hFF, cmdsplit_pkg::CHAR_SQUOTE, 8'h01, 8'h0D,
                    cmdsplit_pkg::CHAR_SQUOTE, 8'h80, cmdsplit_pkg::CHAR_SQUOTE,
                    cmdsplit_pkg::CHAR_DQUOTE, cmdsplit_pkg::CHAR_BACKSLASH,
                    cmdsplit_pkg::CHAR_DQUOTE, cmdsplit_pkg::CHAR_BACKSLASH, 8'h71,
                    cmdsplit_pkg::CHAR_BACKSLASH, cmdsplit_pkg::CHAR_NEWLINE,
                    cmdsplit_pkg::CHAR_DQUOTE,
                    cmdsplit_pkg::CHAR_DQUOTE, cmdsplit_pkg::CHAR_DQUOTE,
                    cmdsplit_pkg::CHAR_SPACE, cmdsplit_pkg::CHAR_BACKSLASH,
                    cmdsplit_pkg::CHAR_SPACE, cmdsplit_pkg::CHAR_BACKSLASH,
                    cmdsplit_pkg::CHAR_NUL,
                    cmdsplit_pkg::CHAR_DQUOTE, 8'h41, cmdsplit_pkg::CHAR_NUL};
      send_command();

      // Random commands. The flood is slipped in once, early, and does not
      // count toward the random bytes. Idling is switched per command so
      // that stretches without it occur, and is off for the final stretch.
      flood_at     = $urandom_range(1, 12);
      commands     = 0;
      random_bytes = 0;
      while (random_bytes < RANDOM_BYTES) begin
         gaps_on = (random_bytes < RANDOM_BYTES - CALM_BYTES) && ($urandom_range(0, 3) != 0);
         if (commands == flood_at) begin
            add_argument_flood();
         end else begin
            add_command();
            random_bytes += cmd_bytes.size();
         end
         send_command();
         commands++;
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain: wait for every predicted result, then a few more cycles so
      // that a stray extra result would still be caught.
      while (stream_depth != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && stream_depth == 0) begin
         $display("command_line_argument_splitter_tb: PASS");
      end else begin
         $display("command_line_argument_splitter_tb: FAIL");
      end
      $finish;
   end

   // Hard limit, far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("command_line_argument_splitter_tb: FAIL");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/cmdsplit_pkg.sv
hw/rtl/cmdsplit_parser.sv
hw/rtl/cmdsplit_outq.sv
hw/rtl/command_line_argument_splitter.sv
hw/rtl/cmdsplit_checker.sv
verif/command_line_argument_splitter_checker.sv
verif/command_line_argument_splitter_tb.sv
